// ===== rtl/core/ccpb_pkg.sv =====
// Shared types and constants for the constant-color pixel blend.
// Used by ccpb_cfg_regs, ccpb_blend and constant_color_pixel_blend.
`timescale 1ns / 1ps

package ccpb_pkg;

    localparam int PIXEL_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    typedef enum logic
    {
        FMT_RGB565 = 1'b0,
        FMT_RGB888 = 1'b1
    } pix_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_COLOR_RED   = 3'd0,
        REG_COLOR_GREEN = 3'd1,
        REG_COLOR_BLUE  = 3'd2,
        REG_COLOR_ALPHA = 3'd3,
        REG_PIXEL_FMT   = 3'd4
    } cfg_idx_t;

    typedef struct packed
    {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        pix_fmt_t          fmt;
    } blend_cfg_t;

    localparam logic [CHAN_W-1:0] RST_RED   = 8'd255;
    localparam logic [CHAN_W-1:0] RST_GREEN = 8'd32;
    localparam logic [CHAN_W-1:0] RST_BLUE  = 8'd32;
    localparam logic [CHAN_W-1:0] RST_ALPHA = 8'd40;

endpackage

// ===== rtl/core/ccpb_cfg_regs.sv =====
// Configuration register file: overlay color, alpha and pixel format.
// Depends on ccpb_pkg.
`timescale 1ns / 1ps

module ccpb_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ccpb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccpb_pkg::CFG_DAT_W-1:0]   cfg_data,
    output ccpb_pkg::blend_cfg_t             cfg
);
    import ccpb_pkg::*;

    blend_cfg_t cfg_reg;
    blend_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_COLOR_RED:   cfg_next.red   = cfg_data;
                REG_COLOR_GREEN: cfg_next.green = cfg_data;
                REG_COLOR_BLUE:  cfg_next.blue  = cfg_data;
                REG_COLOR_ALPHA: cfg_next.alpha = cfg_data;
                REG_PIXEL_FMT:   cfg_next.fmt   = pix_fmt_t'(cfg_data[0]);
                default:         cfg_next       = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red   <= RST_RED;
            cfg_reg.green <= RST_GREEN;
            cfg_reg.blue  <= RST_BLUE;
            cfg_reg.alpha <= RST_ALPHA;
            cfg_reg.fmt   <= FMT_RGB565;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/ccpb_blend.sv =====
// Combinational blend datapath: unpack, three channel mixers, repack.
// Depends on ccpb_pkg.
`timescale 1ns / 1ps

module ccpb_blend
(
    input  ccpb_pkg::blend_cfg_t              cfg,
    input  logic [ccpb_pkg::PIXEL_W-1:0]      pixel,
    output logic [ccpb_pkg::PIXEL_W-1:0]      result
);
    import ccpb_pkg::*;

    // (src*a + dst*(255-a) + 127) / 255; sum stays below 65535, so
    // x/255 == (x + 1 + (x >> 8)) >> 8 holds exactly.
    function automatic logic [CHAN_W-1:0] mix8(input logic [CHAN_W-1:0] dst,
                                               input logic [CHAN_W-1:0] src,
                                               input logic [CHAN_W-1:0] a);
        logic [CHAN_W-1:0]   inv;
        logic [2*CHAN_W-1:0] acc;
        logic [2*CHAN_W-1:0] adj;
        begin
            inv = 8'hFF - a;
            acc = (16'(src) * 16'(a)) + (16'(dst) * 16'(inv)) + 16'd127;
            adj = acc + 16'd1 + {8'd0, acc[15:8]};
            mix8 = adj[15:8];
        end
    endfunction

    logic [CHAN_W-1:0] dst_r;
    logic [CHAN_W-1:0] dst_g;
    logic [CHAN_W-1:0] dst_b;
    logic [CHAN_W-1:0] mix_r;
    logic [CHAN_W-1:0] mix_g;
    logic [CHAN_W-1:0] mix_b;

    always_comb
    begin
        if (cfg.fmt == FMT_RGB565)
        begin
            dst_r = {pixel[15:11], pixel[15:13]};
            dst_g = {pixel[10:5], pixel[10:9]};
            dst_b = {pixel[4:0], pixel[4:2]};
        end
        else
        begin
            dst_r = pixel[7:0];
            dst_g = pixel[15:8];
            dst_b = pixel[23:16];
        end
    end

    assign mix_r = mix8(dst_r, cfg.red,   cfg.alpha);
    assign mix_g = mix8(dst_g, cfg.green, cfg.alpha);
    assign mix_b = mix8(dst_b, cfg.blue,  cfg.alpha);

    always_comb
    begin
        if (cfg.fmt == FMT_RGB565)
            result = {8'd0, mix_r[7:3], mix_g[7:2], mix_b[7:3]};
        else
            result = {mix_b, mix_g, mix_r};
    end

endmodule

// ===== rtl/core/constant_color_pixel_blend.sv =====
// Top level of the constant-color pixel blend: input register, blend, result register.
// Depends on ccpb_pkg, ccpb_cfg_regs and ccpb_blend.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, pixel_in[23:0]        | sink
//  out     | out_valid, out_ready, pixel_out[23:0]     | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// One word per clock while out_ready is high; out_valid is the result register's flag.
// The input register and result register form a two-stage pipeline; the blend
// (two 8x8 multiplies and a divide-by-255 add per channel) sits between them.
// A stalled out_ready holds the result register and backs up into the input register.
// Reset clears the valid flags and loads the color registers with their defaults.
`timescale 1ns / 1ps

module constant_color_pixel_blend
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ccpb_pkg::PIXEL_W-1:0]     pixel_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ccpb_pkg::PIXEL_W-1:0]     pixel_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ccpb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccpb_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import ccpb_pkg::*;

    blend_cfg_t         cfg;
    logic [PIXEL_W-1:0] pixel_reg;
    logic               stage_valid_reg;
    logic [PIXEL_W-1:0] result_reg;
    logic               result_valid_reg;
    logic [PIXEL_W-1:0] blend_out;
    logic               result_load;

    ccpb_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccpb_blend u_blend
    (
        .cfg    (cfg),
        .pixel  (pixel_reg),
        .result (blend_out)
    );

    assign result_load = !result_valid_reg || out_ready;
    assign in_ready    = !stage_valid_reg || result_load;
    assign out_valid   = result_valid_reg;
    assign pixel_out   = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                stage_valid_reg <= in_valid;
            if (result_load)
                result_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            pixel_reg <= pixel_in;
        if (result_load && stage_valid_reg)
            result_reg <= blend_out;
    end

endmodule

// ===== verif/constant_color_pixel_blend_tb.sv =====
// Self-checking testbench for constant_color_pixel_blend: directed and random pixels
// across overlay colors, alpha values and both pixel formats. Depends on ccpb_pkg.
`timescale 1ns / 1ps

module constant_color_pixel_blend_tb;

    import ccpb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 8;
    localparam int PIXELS_PER_PHASE = 80;
    localparam int HOLD_OFF_CYCLES = 64;

    class blend_scoreboard;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        pix_fmt_t           fmt;
        logic [PIXEL_W-1:0] expected_pixels[$];
        int                 errors;
        int                 checked;

        function new();
            red     = RST_RED;
            green   = RST_GREEN;
            blue    = RST_BLUE;
            alpha   = RST_ALPHA;
            fmt     = FMT_RGB565;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_COLOR_RED:   red   = data;
                REG_COLOR_GREEN: green = data;
                REG_COLOR_BLUE:  blue  = data;
                REG_COLOR_ALPHA: alpha = data;
                REG_PIXEL_FMT:   fmt   = pix_fmt_t'(data[0]);
                default: ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] mix(logic [CHAN_W-1:0] dst, logic [CHAN_W-1:0] src);
            int unsigned s;
            int unsigned d;
            int unsigned a;
            int unsigned acc;
            s   = src;
            d   = dst;
            a   = alpha;
            acc = s * a + d * (255 - a) + 127;
            return CHAN_W'(acc / 255);
        endfunction

        function logic [PIXEL_W-1:0] blend_pixel(logic [PIXEL_W-1:0] px);
            logic [4:0]        r5;
            logic [5:0]        g6;
            logic [4:0]        b5;
            logic [CHAN_W-1:0] r;
            logic [CHAN_W-1:0] g;
            logic [CHAN_W-1:0] b;
            if (fmt == FMT_RGB565)
            begin
                if (alpha == 0)
                    return {8'h00, px[15:0]};
                r5 = px[15:11];
                g6 = px[10:5];
                b5 = px[4:0];
                r  = mix({r5, r5[4:2]}, red);
                g  = mix({g6, g6[5:4]}, green);
                b  = mix({b5, b5[4:2]}, blue);
                return {8'h00, r[7:3], g[7:2], b[7:3]};
            end
            if (alpha == 0)
                return px;
            return {mix(px[23:16], blue), mix(px[15:8], green), mix(px[7:0], red)};
        endfunction

        function void note_input(logic [PIXEL_W-1:0] px);
            expected_pixels.push_back(blend_pixel(px));
        endfunction

        function void check_result(logic [PIXEL_W-1:0] px);
            logic [PIXEL_W-1:0] want;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %06h", $time, px);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (px !== want)
            begin
                $display("%0t: pixel_out mismatch, expected %06h, actual %06h",
                         $time, want, px);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [PIXEL_W-1:0]   pixel_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIXEL_W-1:0]   pixel_out;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    blend_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int cycle_count;
    int pixels_sent;
    int reg_writes;
    int settings;

    constant_color_pixel_blend dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(pixel_in);
            if (out_valid && out_ready)
                sb.check_result(pixel_out);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin : receiver
        int hold_left;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg_word(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_colors(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic [7:0] f);
        wait_for_drain();
        write_reg_word(REG_COLOR_RED, r);
        write_reg_word(REG_COLOR_GREEN, g);
        write_reg_word(REG_COLOR_BLUE, b);
        write_reg_word(REG_COLOR_ALPHA, a);
        write_reg_word(REG_PIXEL_FMT, f);
        settings++;
    endtask

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'hFE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    task automatic random_setting();
        logic [CFG_IDX_W-1:0] idx;
        int                   first;
        wait_for_drain();
        first = $urandom_range(4);
        for (int k = 0; k < 5; k++)
        begin
            idx = CFG_IDX_W'((first + k) % 5);
            if (idx == REG_PIXEL_FMT)
                write_reg_word(idx, 8'($urandom));
            else
                write_reg_word(idx, pick_chan());
        end
        if ($urandom_range(3) == 0)
            write_reg_word(CFG_IDX_W'($urandom_range(7, 5)), 8'($urandom));
        settings++;
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pixel_in       = '0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        cycle_count    = 0;
        pixels_sent    = 0;
        reg_writes     = 0;
        settings       = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset colors, RGB565: extremes, upper byte ignored, pure channels
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h00FFFF);
        send_pixel(24'hFF0000);
        send_pixel(24'h00F800);
        send_pixel(24'h0007E0);
        send_pixel(24'h00001F);
        end_burst();

        // alpha zero passes the pixel through; format data wider than one bit
        set_colors(8'h5A, 8'hA5, 8'h3C, 8'h00, 8'hFF);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h123456);
        send_pixel(24'h000000);
        end_burst();
        set_colors(8'h5A, 8'hA5, 8'h3C, 8'h00, 8'hFE);
        send_pixel(24'hABCDEF);
        send_pixel(24'h00FFFF);
        end_burst();

        // fully opaque overlay in both formats
        set_colors(8'h00, 8'hFF, 8'h80, 8'hFF, 8'h01);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h808080);
        end_burst();
        set_colors(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00);
        send_pixel(24'h000000);
        send_pixel(24'h00FFFF);
        end_burst();

        // writes past the register list change nothing
        wait_for_drain();
        write_reg_word(3'd5, 8'h00);
        write_reg_word(3'd6, 8'h55);
        write_reg_word(3'd7, 8'hFF);
        send_pixel(24'h3F7C21);
        send_pixel(24'hC0FFEE);
        end_burst();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            random_setting();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (p == 4)
            begin
                @(posedge clk);
                hold_request = HOLD_OFF_CYCLES;
            end
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
                send_pixel(pick_pixel());
            end_burst();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("Blended %0d pixels under %0d color/alpha/format settings, RGB565 and RGB888.",
                 pixels_sent, settings);
        $display("Checked %0d words, %0d register writes, idle, stall and hold-off phases.",
                 sb.checked, reg_writes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
